/* rtl/gcd_pkg.sv */
package gcd_pkg;

	typedef enum logic [1:0] {
		ACT_LOAD_A  = 2'd0,
		ACT_LOAD_B  = 2'd1,
		ACT_COMPUTE = 2'd2,
		ACT_CLEAR   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_DISJ_COEF = 2'd1,
		REG_EXC_COEF  = 2'd2,
		REG_WGT_COEF  = 2'd3
	} reg_index_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FETCH,
		S_STEP,
		S_MUL,
		S_DIV1_GO,
		S_DIV1,
		S_DIV2_GO,
		S_DIV2,
		S_SUM,
		S_OUT
	} state_t;

	localparam int THR_W  = 11;
	localparam int COEF_W = 16;
	localparam int DIST_W = 48;
	localparam int DISJ_OUT_W = 12;
	localparam int EXC_OUT_W  = 11;

	typedef struct packed {
		logic load_a;
		logic load_b;
		logic clear;
		logic init;
		logic step;
		logic mul;
		logic div_start;
		logic div_sel;
		logic cap_q1;
		logic cap_q2;
		logic sum;
	} cmd_t;

	typedef struct packed {
		logic walk_more;
		logic div_busy;
	} status_t;

endpackage

/* rtl/gcd_ctrl.sv */
module gcd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       action,
	input  gcd_pkg::status_t st,
	output gcd_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done
);
	import gcd_pkg::*;

	state_t state_q, state_d;
	logic   take;

	assign take = start && (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != S_IDLE);
		done    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					unique case (action_t'(action))
						ACT_LOAD_A:  cmd.load_a = 1'b1;
						ACT_LOAD_B:  cmd.load_b = 1'b1;
						ACT_CLEAR:   cmd.clear = 1'b1;
						ACT_COMPUTE: begin
							cmd.init = 1'b1;
							state_d  = S_FETCH;
						end
						default: ;
					endcase
				end
			end
			S_FETCH: state_d = st.walk_more ? S_STEP : S_MUL;
			S_STEP: begin
				cmd.step = 1'b1;
				state_d  = S_FETCH;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIV1_GO;
			end
			S_DIV1_GO: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV1;
			end
			S_DIV1: begin
				if (!st.div_busy) begin
					cmd.cap_q1 = 1'b1;
					state_d    = S_DIV2_GO;
				end
			end
			S_DIV2_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = 1'b1;
				state_d       = S_DIV2;
			end
			S_DIV2: begin
				if (!st.div_busy) begin
					cmd.cap_q2 = 1'b1;
					state_d    = S_SUM;
				end
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				done    = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> st.walk_more) else $error("merge step past list end");
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(take && action == ACT_COMPUTE) |=> busy) else $error("compute not busy");
	a_idle_no_loads: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !(cmd.load_a || cmd.load_b || cmd.clear)) else $error("load while busy");

endmodule

/* rtl/gcd_dp.sv */
module gcd_dp #(
	parameter int MAX_GENES = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gcd_pkg::cmd_t                cmd,
	output gcd_pkg::status_t             st,
	input  logic [15:0]                  gene_id,
	input  logic signed [15:0]           gene_weight,
	input  logic [gcd_pkg::THR_W-1:0]    thr,
	input  logic [gcd_pkg::COEF_W-1:0]   c1,
	input  logic [gcd_pkg::COEF_W-1:0]   c2,
	input  logic [gcd_pkg::COEF_W-1:0]   c3,
	output logic [gcd_pkg::DIST_W-1:0]   distance,
	output logic [gcd_pkg::DISJ_OUT_W-1:0] disjoint_count,
	output logic [gcd_pkg::EXC_OUT_W-1:0]  excess_count,
	output logic                         overflow
);
	import gcd_pkg::*;

	localparam int AW   = (MAX_GENES > 1) ? $clog2(MAX_GENES) : 1;
	localparam int LW   = $clog2(MAX_GENES + 1);
	localparam int DW   = LW + 1;
	localparam int WSW  = LW + 17;
	localparam int NW   = COEF_W + DW + 8;
	localparam int T3W  = COEF_W + WSW;
	localparam int TW   = ((T3W > NW) ? T3W : NW) + 2;
	localparam int TXW  = (TW > DIST_W + 9) ? TW : DIST_W + 9;
	localparam int CW   = $clog2(NW + 1);

	logic [31:0] mem_a [MAX_GENES];
	logic [31:0] mem_b [MAX_GENES];
	logic [31:0] rd_a_q, rd_b_q;

	logic [LW-1:0]  len_a_q, len_b_q, ia_q, ib_q, n_q, nmax, exc;
	logic           ovf_q;
	logic [DW-1:0]  disj_q;
	logic [WSW-1:0] wsum_q;
	logic [NW-1:0]  num1_q, num2_q, quo_q, q1_q, q2_q;
	logic [T3W-1:0] t3_q;
	logic [LW-1:0]  rem_q;
	logic [CW-1:0]  cnt_q;
	logic [LW:0]    rem_sh;
	logic signed [16:0] wdiff;
	logic [16:0]    wabs;
	logic [TXW-1:0] total;
	logic [TXW-9:0] shifted;

	// list stores, registered read
	always_ff @(posedge clk) begin
		if (cmd.load_a && len_a_q < LW'(MAX_GENES))
			mem_a[len_a_q[AW-1:0]] <= {gene_id, gene_weight};
		if (cmd.load_b && len_b_q < LW'(MAX_GENES))
			mem_b[len_b_q[AW-1:0]] <= {gene_id, gene_weight};
		rd_a_q <= mem_a[ia_q[AW-1:0]];
		rd_b_q <= mem_b[ib_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_a_q <= '0;
			len_b_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.clear) begin
			len_a_q <= '0;
			len_b_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (cmd.load_a) begin
				if (len_a_q < LW'(MAX_GENES)) len_a_q <= len_a_q + 1'b1;
				else ovf_q <= 1'b1;
			end
			if (cmd.load_b) begin
				if (len_b_q < LW'(MAX_GENES)) len_b_q <= len_b_q + 1'b1;
				else ovf_q <= 1'b1;
			end
		end
	end

	assign nmax  = (len_a_q > len_b_q) ? len_a_q : len_b_q;
	assign exc   = (ia_q == len_a_q) ? (len_b_q - ib_q) : (len_a_q - ia_q);
	assign wdiff = 17'(signed'(rd_a_q[15:0])) - 17'(signed'(rd_b_q[15:0]));
	assign wabs  = wdiff[16] ? 17'(-wdiff) : 17'(wdiff);

	assign st.walk_more = (ia_q < len_a_q) && (ib_q < len_b_q);
	assign st.div_busy  = (cnt_q != '0);

	// merge walk
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			ia_q   <= '0;
			ib_q   <= '0;
			disj_q <= '0;
			wsum_q <= '0;
			n_q    <= (32'(nmax) < 32'(thr)) ? LW'(1) : nmax;
		end else if (cmd.step) begin
			if (rd_a_q[31:16] == rd_b_q[31:16]) begin
				wsum_q <= wsum_q + WSW'(wabs);
				ia_q   <= ia_q + 1'b1;
				ib_q   <= ib_q + 1'b1;
			end else if (rd_a_q[31:16] < rd_b_q[31:16]) begin
				disj_q <= disj_q + 1'b1;
				ia_q   <= ia_q + 1'b1;
			end else begin
				disj_q <= disj_q + 1'b1;
				ib_q   <= ib_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			num1_q <= {(COEF_W + DW)'(c1) * (COEF_W + DW)'(disj_q), 8'd0};
			num2_q <= {(COEF_W + DW)'(c2) * (COEF_W + DW)'(exc), 8'd0};
			t3_q   <= T3W'(c3) * T3W'(wsum_q);
		end
	end

	// restoring divider, one quotient bit a cycle
	assign rem_sh = {rem_q, quo_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= CW'(NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= cmd.div_sel ? num2_q : num1_q;
		end else if (cnt_q != '0) begin
			if (rem_sh >= {1'b0, n_q}) begin
				rem_q <= LW'(rem_sh - {1'b0, n_q});
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[LW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
		if (cmd.cap_q1) q1_q <= (n_q == '0) ? '0 : quo_q;
		if (cmd.cap_q2) q2_q <= (n_q == '0) ? '0 : quo_q;
	end

	assign total   = TXW'(t3_q) + TXW'(q1_q) + TXW'(q2_q);
	assign shifted = total[TXW-1:8];

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			distance       <= (|shifted[TXW-9:DIST_W]) ? {DIST_W{1'b1}} :
			                  shifted[DIST_W-1:0];
			disjoint_count <= (32'(disj_q) > 32'(4095)) ? {DISJ_OUT_W{1'b1}} :
			                  DISJ_OUT_W'(disj_q);
			excess_count   <= (32'(exc) > 32'(2047)) ? {EXC_OUT_W{1'b1}} :
			                  EXC_OUT_W'(exc);
			overflow       <= ovf_q;
		end
	end

endmodule

/* rtl/genome_compatibility_distance_top.sv */
// channel   | signals                                      | transfer
// ----------+----------------------------------------------+---------------------------
// command   | start, busy, action, gene_id, gene_weight    | start high while busy low
// result    | done, distance, disjoint_count, excess_count,| done high for one cycle
//           | overflow                                     |
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data    | cfg_valid and cfg_ready high
//
// loads and clears never raise busy, so genes may stream in every cycle while busy is
// low; a compute holds busy through each merge step (registered list read, then
// compare), a check that the walk is over, a multiply step, two serial divides of
// a start step, a shift step per quotient bit and a capture step each, then a sum
// step and the result step
// arst_n clears the state machine, list lengths and overflow flag; the coefficient
// registers return to their defaults; list contents are undefined until loaded
// the receiver cannot stall, so the result is shown exactly once on done
module genome_compatibility_distance_top #(
	parameter int MAX_GENES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [15:0] gene_id,
	input  logic signed [15:0] gene_weight,
	output logic        done,
	output logic [47:0] distance,
	output logic [11:0] disjoint_count,
	output logic [10:0] excess_count,
	output logic        overflow,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import gcd_pkg::*;

	cmd_t    cmd;
	status_t st;

	logic [THR_W-1:0]  thr_q;
	logic [COEF_W-1:0] c1_q, c2_q, c3_q;

	// registers only change while no compute is running
	assign cfg_ready = !busy;

	// coefficient register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_W'(20);
			c1_q  <= COEF_W'(256);
			c2_q  <= COEF_W'(256);
			c3_q  <= COEF_W'(102);
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_THRESHOLD: thr_q <= cfg_data[THR_W-1:0];
				REG_DISJ_COEF: c1_q  <= cfg_data;
				REG_EXC_COEF:  c2_q  <= cfg_data;
				REG_WGT_COEF:  c3_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer for load, clear and the compute steps
	gcd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// list stores, merge walk, multipliers and shared divider
	gcd_dp #(.MAX_GENES(MAX_GENES)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.gene_id        (gene_id),
		.gene_weight    (gene_weight),
		.thr            (thr_q),
		.c1             (c1_q),
		.c2             (c2_q),
		.c3             (c3_q),
		.distance       (distance),
		.disjoint_count (disjoint_count),
		.excess_count   (excess_count),
		.overflow       (overflow)
	);

endmodule
